// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/wwps_pkg.sv =====
// ----------------------------------------------------------------------------
// wwps_pkg
// Types, constants and byte helpers of the whole-word phrase search.
// ----------------------------------------------------------------------------
package wwps_pkg;

    localparam int MAX_PHRASE_DEF = 16;   // default window depth
    localparam int PHRASE_CAP     = 16;   // bytes held by the phrase registers
    localparam int PHRASE_W       = 8 * PHRASE_CAP;
    localparam int LEN_W          = 5;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 2;

    typedef logic [7:0]            t_byte;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_PHRASE_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_PHRASE_LOW    = 2'd1;
    localparam t_cfg_idx CFG_PHRASE_HIGH   = 2'd2;

    // ASCII A-Z to a-z, everything else untouched
    function automatic t_byte to_lower(input t_byte b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

    function automatic logic is_alnum(input t_byte b);
        return (b >= 8'h30 && b <= 8'h39) ||
               (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

endpackage

// ===== src/wwps_if.sv =====
// ----------------------------------------------------------------------------
// wwps_if
// Valid/ready channels of the phrase search: text, result and config write.
// ----------------------------------------------------------------------------
interface wwps_text_if;
    import wwps_pkg::*;
    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  is_final;

    modport source (output valid, output text_byte, output is_final, input ready);
    modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

interface wwps_result_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

interface wwps_cfg_if;
    import wwps_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/wwps_match.sv =====
// ----------------------------------------------------------------------------
// wwps_match
// Parallel compare of the phrase against the newest bytes of a window,
// with the word-start mark on the first phrase byte.
// ----------------------------------------------------------------------------
module wwps_match #(
    parameter int MAX_PHRASE = wwps_pkg::MAX_PHRASE_DEF
) (
    input  wwps_pkg::t_byte                 i_window [MAX_PHRASE],
    input  logic [MAX_PHRASE-1:0]           i_marks,
    input  logic [wwps_pkg::LEN_W-1:0]      i_seen,
    input  logic [wwps_pkg::LEN_W-1:0]      i_len,
    input  logic [wwps_pkg::PHRASE_W-1:0]   i_phrase,
    output logic                            o_match
);
    import wwps_pkg::*;

    localparam int IDX_W = (MAX_PHRASE > 1) ? $clog2(MAX_PHRASE) : 1;

    logic             len_ok;
    logic             mark_ok;
    logic             bytes_ok;
    logic [LEN_W-1:0] last;

    assign len_ok  = (i_len != '0) && (i_len <= LEN_W'(MAX_PHRASE)) && (i_seen >= i_len);
    assign last    = i_len - LEN_W'(1);
    assign mark_ok = len_ok && i_marks[last[IDX_W-1:0]];

    // phrase byte k sits len-1-k positions back from the newest byte
    always_comb begin
        logic [LEN_W-1:0] pos;
        bytes_ok = 1'b1;
        pos      = '0;
        for (int k = 0; k < MAX_PHRASE; k++) begin
            pos = i_len - LEN_W'(k + 1);
            if ((LEN_W'(k) < i_len) && (pos < LEN_W'(MAX_PHRASE))) begin
                if (i_window[pos[IDX_W-1:0]] != i_phrase[8*k +: 8]) begin
                    bytes_ok = 1'b0;
                end
            end
        end
    end

    assign o_match = mark_ok && bytes_ok;

endmodule

// ===== src/whole_word_phrase_search_core.sv =====
// ----------------------------------------------------------------------------
// whole_word_phrase_search_core
// Streams text bytes and reports, on the last byte of each text, whether the
// configured phrase occurs at a word start followed by a word boundary.
//
//   channel    dir   handshake      payload
//   i_text     in    valid/ready    text_byte[7:0], is_final
//   o_result   out   valid/ready    found (one request per text)
//   i_cfg      in    valid/ready    index[1:0], data[63:0] (ready tied high)
//
// One byte per cycle while no final byte waits on a stalled result; a final
// byte passes the input register, then the result register, as its result.
// The window update and both compares sit between those two registers.
// Reset is synchronous; it zeroes the phrase and length and clears the per-text state, setting the start flag.
// A stalled result holds back a final byte and the bytes behind it; other bytes keep flowing.
// ----------------------------------------------------------------------------
module whole_word_phrase_search_core #(
    parameter int MAX_PHRASE = wwps_pkg::MAX_PHRASE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wwps_text_if.sink      i_text,
    wwps_result_if.source  o_result,
    wwps_cfg_if.sink       i_cfg
);
    import wwps_pkg::*;

    localparam int SEEN_W = $clog2(MAX_PHRASE + 1);

    // configuration
    logic [LEN_W-1:0]    r_len;
    logic [PHRASE_W-1:0] r_phrase;

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_final;

    // per-text state
    t_byte               r_window [MAX_PHRASE];
    t_byte               n_window [MAX_PHRASE];
    logic [MAX_PHRASE-1:0] r_marks;
    logic [MAX_PHRASE-1:0] n_marks;
    logic [SEEN_W-1:0]   r_seen;
    logic [SEEN_W-1:0]   n_seen;
    logic                r_prior_alnum;
    logic                r_at_start;
    logic                r_match_seen;

    // result register
    logic r_out_valid;
    logic r_out_found;

    logic  adv;
    t_byte lc_byte;
    logic  alnum;
    logic  mark;
    logic  match_old;
    logic  match_new;
    logic  hit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_phrase <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PHRASE_LENGTH: r_len <= i_cfg.data[LEN_W-1:0];
                CFG_PHRASE_LOW:    r_phrase[CFG_DATA_W-1:0] <= i_cfg.data;
                CFG_PHRASE_HIGH:   r_phrase[PHRASE_W-1:CFG_DATA_W] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // final bytes wait for a free result register
    assign adv          = r_in_valid && (!r_in_final || !r_out_valid || o_result.ready);
    assign i_text.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte  <= i_text.text_byte;
            r_in_final <= i_text.is_final;
        end
    end

    assign lc_byte = to_lower(r_in_byte);
    assign alnum   = is_alnum(lc_byte);
    assign mark    = r_at_start || (alnum && !r_prior_alnum);
    assign n_seen  = (r_seen < SEEN_W'(MAX_PHRASE)) ? r_seen + SEEN_W'(1) : r_seen;

    always_comb begin
        n_window[0] = lc_byte;
        n_marks[0]  = mark;
        for (int i = 1; i < MAX_PHRASE; i++) begin
            n_window[i] = r_window[i-1];
            n_marks[i]  = r_marks[i-1];
        end
    end

    // phrase ending on the previous byte, bounded by this one
    wwps_match #(.MAX_PHRASE(MAX_PHRASE)) u_match_old (
        .i_window (r_window),
        .i_marks  (r_marks),
        .i_seen   (LEN_W'(r_seen)),
        .i_len    (r_len),
        .i_phrase (r_phrase),
        .o_match  (match_old)
    );

    // phrase ending on this byte, bounded by end of text
    wwps_match #(.MAX_PHRASE(MAX_PHRASE)) u_match_new (
        .i_window (n_window),
        .i_marks  (n_marks),
        .i_seen   (LEN_W'(n_seen)),
        .i_len    (r_len),
        .i_phrase (r_phrase),
        .o_match  (match_new)
    );

    assign hit = r_match_seen || (!alnum && match_old);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < MAX_PHRASE; i++) begin
                r_window[i] <= n_window[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks       <= '0;
            r_seen        <= '0;
            r_prior_alnum <= 1'b0;
            r_at_start    <= 1'b1;
            r_match_seen  <= 1'b0;
        end else if (adv) begin
            r_marks <= n_marks;
            if (r_in_final) begin
                r_seen        <= '0;
                r_prior_alnum <= 1'b0;
                r_at_start    <= 1'b1;
                r_match_seen  <= 1'b0;
            end else begin
                r_seen        <= n_seen;
                r_prior_alnum <= alnum;
                r_at_start    <= 1'b0;
                r_match_seen  <= hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_final) begin
            r_out_found <= hit || match_new;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.found = r_out_found;

endmodule

// ===== src/wwps_checker.sv =====
// ----------------------------------------------------------------------------
// wwps_checker
// Port-level checks of the phrase search core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wwps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_found
);

    // a pending result holds until taken
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result request dropped while stalled")

    `ASSERT_CLK(a_found_stable, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> $stable(i_out_found), "found changed while stalled")

    `ASSERT_CLK_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid, "result request after reset")

    // with no result pending nothing may hold back the text
    `ASSERT_CLK(a_in_free, i_clk, i_rst_n, (!i_out_valid && !i_in_valid) |=> (!i_out_valid || i_in_ready || $past(i_in_ready)), "text blocked with empty result register")

endmodule

bind whole_word_phrase_search_core wwps_checker u_wwps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_text.valid),
    .i_in_ready  (i_text.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_found (o_result.found)
);
